>>> sv/slra_pkg.sv
// slra_pkg: request/response types, opcodes and status codes for the
// reference-counted slot allocator. No dependencies.
`default_nettype none

package slra_pkg;

    // opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_DROP  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // response status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;
    localparam logic [1:0] ST_MAX  = 2'd3;

    // free bitmap word geometry
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;

    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  result_slot;
        logic [15:0] new_count;
        logic        slot_released;
    } rsp_t;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] slot_index;
        logic       in_table;
    } cmd_t;

endpackage

`default_nettype wire

>>> sv/slra_ram.sv
// slra_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none

module slra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/slra_front.sv
// slra_front: accepts requests and classifies them into commands.
// Depends on slra_pkg.
`default_nettype none

module slra_front #(
    parameter int SLOT_COUNT = 1024
) (
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire slra_pkg::req_t req,
    input  wire logic          q_full,
    input  wire logic          clearing,
    output logic               push,
    output slra_pkg::cmd_t     push_cmd
);
    import slra_pkg::*;

    // hold off requests while the queue is full or the bitmap is being cleared
    assign req_stall = q_full | clearing;
    assign push      = req_valid & ~req_stall;

    // classify: does the index land inside the table
    always_comb
    begin
        push_cmd.opcode     = req.opcode;
        push_cmd.slot_index = req.slot_index;
        push_cmd.in_table   = (32'(req.slot_index) < SLOT_COUNT);
    end

endmodule

`default_nettype wire

>>> sv/slra_queue.sv
// slra_queue: two-entry command queue between front and back.
// Depends on slra_pkg.
`default_nettype none

module slra_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire slra_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output slra_pkg::cmd_t     head_cmd
);
    import slra_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full       = fill_reg[1];
    assign head_valid = (fill_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/slra_back.sv
// slra_back: executes commands against the count RAM and the free bitmap,
// and holds the response register. Depends on slra_pkg and slra_ram.
`default_nettype none

module slra_back #(
    parameter int SLOT_COUNT = 1024,
    parameter int COUNT_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire slra_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               clearing,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output slra_pkg::rsp_t     rsp
);
    import slra_pkg::*;

    localparam int NWORDS     = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WSEL_BITS  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int ALLOC_BITS = WSEL_BITS + WORD_SHIFT;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [WSEL_BITS-1:0]  LAST_WORD = WSEL_BITS'(NWORDS - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [WSEL_BITS-1:0]  clr_cnt_reg;
    logic [WSEL_BITS-1:0]  clr_cnt_next;
    cmd_t                  cmd_reg;
    cmd_t                  cmd_next;
    logic                  found_reg;
    logic                  found_next;
    logic [WSEL_BITS-1:0]  word_reg;
    logic [WSEL_BITS-1:0]  word_next;
    logic [NWORDS-1:0]     word_full_reg;
    logic [NWORDS-1:0]     word_full_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    rsp_t                  out_reg;
    rsp_t                  out_next;

    // RAM ports
    logic                  bm_we;
    logic [WSEL_BITS-1:0]  bm_waddr;
    logic [WORD_BITS-1:0]  bm_wdata;
    logic                  bm_re;
    logic [WSEL_BITS-1:0]  bm_raddr;
    logic [WORD_BITS-1:0]  bm_rdata;
    logic                  cnt_we;
    logic [SLOT_BITS-1:0]  cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  cnt_re;
    logic [SLOT_BITS-1:0]  cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_rdata;

    // decoded addresses
    logic [ALLOC_BITS-1:0] q_eaddr;
    logic [ALLOC_BITS-1:0] c_eaddr;
    logic [WSEL_BITS-1:0]  c_word;
    logic [WORD_SHIFT-1:0] c_bit;
    logic [WORD_BITS-1:0]  c_mask;
    logic                  c_used;
    logic [COUNT_BITS-1:0] cur;
    logic                  free_word_found;
    logic [WSEL_BITS-1:0]  free_word;
    logic [WORD_SHIFT-1:0] free_bit;
    logic [ALLOC_BITS-1:0] alloc_slot;
    logic [WORD_BITS-1:0]  pad_word;
    logic                  go;

    slra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    slra_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign clearing  = (state_reg == S_CLEAR);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign go        = ~out_valid_reg | ~rsp_stall;

    // address split for queued and current commands
    always_comb
    begin
        q_eaddr = ALLOC_BITS'(q_cmd.slot_index);
        c_eaddr = ALLOC_BITS'(cmd_reg.slot_index);
        c_word  = c_eaddr[ALLOC_BITS-1:WORD_SHIFT];
        c_bit   = c_eaddr[WORD_SHIFT-1:0];
        c_mask  = WORD_BITS'(1) << c_bit;
        c_used  = bm_rdata[c_bit];
        cur     = (cmd_reg.in_table && c_used) ? cnt_rdata : '0;
    end

    // lowest word with a free slot
    always_comb
    begin
        free_word_found = 1'b0;
        free_word       = '0;
        for (int w = NWORDS - 1; w >= 0; w--)
        begin
            if (!word_full_reg[w])
            begin
                free_word_found = 1'b1;
                free_word       = WSEL_BITS'(w);
            end
        end
    end

    // lowest free bit in the fetched bitmap word
    always_comb
    begin
        free_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!bm_rdata[b])
            begin
                free_bit = WORD_SHIFT'(b);
            end
        end
        alloc_slot = {word_reg, free_bit};
    end

    // bits past the end of the table are marked permanently used
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            pad_word[b] = ((int'(clr_cnt_reg) * WORD_BITS + b) >= SLOT_COUNT);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_next       = cmd_reg;
        found_next     = found_reg;
        word_next      = word_reg;
        word_full_next = word_full_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & rsp_stall;
        q_pop          = 1'b0;
        bm_we          = 1'b0;
        bm_waddr       = c_word;
        bm_wdata       = bm_rdata;
        bm_re          = 1'b0;
        bm_raddr       = q_eaddr[ALLOC_BITS-1:WORD_SHIFT];
        cnt_we         = 1'b0;
        cnt_waddr      = SLOT_BITS'(c_eaddr);
        cnt_wdata      = '0;
        cnt_re         = 1'b0;
        cnt_raddr      = SLOT_BITS'(q_eaddr);

        unique case (state_reg)
            S_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_waddr = clr_cnt_reg;
                bm_wdata = pad_word;
                clr_cnt_next = clr_cnt_reg + WSEL_BITS'(1);
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    found_next = free_word_found;
                    word_next  = free_word;
                    if (q_cmd.opcode == OP_ALLOC)
                    begin
                        bm_re    = free_word_found;
                        bm_raddr = free_word;
                    end
                    else
                    begin
                        bm_re  = q_cmd.in_table;
                        cnt_re = q_cmd.in_table;
                    end
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (go)
                begin
                    state_next               = S_IDLE;
                    out_valid_next           = 1'b1;
                    out_next.status          = ST_OK;
                    out_next.result_slot     = cmd_reg.slot_index;
                    out_next.new_count       = 16'(cur);
                    out_next.slot_released   = 1'b0;
                    unique case (cmd_reg.opcode)
                        OP_ALLOC:
                        begin
                            if (!found_reg)
                            begin
                                out_next.status      = ST_FULL;
                                out_next.result_slot = '0;
                                out_next.new_count   = '0;
                            end
                            else
                            begin
                                bm_we     = 1'b1;
                                bm_waddr  = word_reg;
                                bm_wdata  = bm_rdata | (WORD_BITS'(1) << free_bit);
                                word_full_next[word_reg] = &bm_wdata;
                                cnt_we    = 1'b1;
                                cnt_waddr = SLOT_BITS'(alloc_slot);
                                cnt_wdata = COUNT_BITS'(1);
                                out_next.result_slot = 10'(alloc_slot);
                                out_next.new_count   = 16'd1;
                            end
                        end

                        OP_ADD:
                        begin
                            if (!cmd_reg.in_table)
                            begin
                                out_next.status    = ST_FREE;
                                out_next.new_count = '0;
                            end
                            else if (cur == COUNT_MAX)
                            begin
                                out_next.status = ST_MAX;
                            end
                            else
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cur + COUNT_BITS'(1);
                                out_next.new_count = 16'(cnt_wdata);
                                // first reference marks the slot used
                                if (!c_used)
                                begin
                                    bm_we    = 1'b1;
                                    bm_wdata = bm_rdata | c_mask;
                                    word_full_next[c_word] = &bm_wdata;
                                end
                            end
                        end

                        OP_DROP:
                        begin
                            if (!cmd_reg.in_table || cur == '0)
                            begin
                                out_next.status    = ST_FREE;
                                out_next.new_count = '0;
                            end
                            else
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cur - COUNT_BITS'(1);
                                out_next.new_count = 16'(cnt_wdata);
                                // last reference frees the slot
                                if (cnt_wdata == '0)
                                begin
                                    bm_we    = 1'b1;
                                    bm_wdata = bm_rdata & ~c_mask;
                                    word_full_next[c_word] = 1'b0;
                                    out_next.slot_released = 1'b1;
                                end
                            end
                        end

                        OP_NOP:
                        begin
                            out_next.status = ST_OK;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            word_full_reg <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            word_full_reg <= word_full_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

>>> sv/refcounted_slot_allocator.sv
// Reference-counted first-fit slot allocator.
// An accepted request is queued, then the back end reads the bitmap/count RAMs, executes, writes back
// and registers the response; the next request waits for that, and rsp_stall holds execution.
// Lowest free slot comes from per-word full flags plus a 32-bit free bitmap word.
// Reset: asynchronous, active low; then a clearing pass over every bitmap word, during which
// req_stall stays high.
`default_nettype none

module refcounted_slot_allocator #(
    parameter int SLOT_COUNT = 1024,
    parameter int COUNT_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire slra_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output slra_pkg::rsp_t      rsp
);
    import slra_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;
    logic clearing;

    // request intake and classification
    slra_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // decoupling queue
    slra_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    // execution and response register
    slra_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
